@@ rtl/pfr_pkg.sv @@
`default_nettype none

package pfr_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 63;
  localparam int unsigned DEG_W          = 6;
  localparam int unsigned ROOT_W         = 32;
  localparam int unsigned COEF_W         = 64;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_ROOT  = 2'd1;
  localparam logic [1:0] OP_EMIT  = 2'd2;

  typedef struct packed {
    logic [1:0]               operation;
    logic signed [ROOT_W-1:0] root;
  } in_item_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [DEG_W-1:0]         power;
    logic                     last;
    logic                     overflow;
  } out_item_t;

  // Work handed from the front to the back. Dropped roots and unused codes never get here.
  typedef enum logic [1:0] {
    CMD_START,
    CMD_FIRST,
    CMD_MUL,
    CMD_EMIT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic signed [ROOT_W-1:0] root;
    logic [DEG_W-1:0]         degree;
    logic                     overflow;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIRST,
    BK_MUL,
    BK_DRAIN,
    BK_EMIT
  } back_state_t;

  typedef struct packed {
    logic [DEG_W-1:0] power;
    logic             last;
    logic             overflow;
  } emit_tag_t;

endpackage

`default_nettype wire

@@ rtl/pfr_ram.sv @@
`default_nettype none

module pfr_ram #(
  parameter int unsigned WIDTH = pfr_pkg::COEF_W,
  parameter int unsigned DEPTH = pfr_pkg::MAX_DEGREE_DEF + 1
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       re,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pfr_front.sv @@
`default_nettype none

module pfr_front #(
  parameter int unsigned MAX_DEGREE = pfr_pkg::MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfr_pkg::in_item_t in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output pfr_pkg::cmd_t     push_cmd
);
  import pfr_pkg::*;

  logic [DEG_W-1:0] deg_r, deg_nxt;
  logic             has_roots_r, has_roots_nxt;
  logic             ovf_r, ovf_nxt;
  logic             accept;

  assign in_ready = push_ready;
  assign accept   = in_valid & push_ready;

  // The front tracks degree and overflow itself, so the back only sees work to do.
  always_comb begin
    deg_nxt       = deg_r;
    has_roots_nxt = has_roots_r;
    ovf_nxt       = ovf_r;
    push_valid    = 1'b0;
    push_cmd      = '{kind: CMD_START, root: in_data.root, degree: deg_r, overflow: ovf_r};
    if (accept) begin
      unique case (in_data.operation)
        OP_START: begin
          deg_nxt       = '0;
          has_roots_nxt = 1'b0;
          ovf_nxt       = 1'b0;
          push_valid    = 1'b1;
          push_cmd.kind = CMD_START;
        end
        OP_ROOT: begin
          if (!has_roots_r) begin
            has_roots_nxt = 1'b1;
            deg_nxt       = DEG_W'(1);
            push_valid    = 1'b1;
            push_cmd.kind = CMD_FIRST;
          end else if (deg_r >= DEG_W'(MAX_DEGREE)) begin
            ovf_nxt = 1'b1;
          end else begin
            deg_nxt       = deg_r + 1'b1;
            push_valid    = 1'b1;
            push_cmd.kind = CMD_MUL;
          end
        end
        OP_EMIT: begin
          push_valid    = 1'b1;
          push_cmd.kind = CMD_EMIT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deg_r       <= '0;
      has_roots_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      deg_r       <= deg_nxt;
      has_roots_r <= has_roots_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pfr_queue.sv @@
`default_nettype none

module pfr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  pfr_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pfr_pkg::cmd_t pop_cmd
);
  import pfr_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          slots_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

@@ rtl/pfr_back.sv @@
`default_nettype none

module pfr_back #(
  parameter int unsigned MAX_DEGREE = pfr_pkg::MAX_DEGREE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  pfr_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output pfr_pkg::out_item_t out_data
);
  import pfr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_DEGREE + 1);

  back_state_t              state_r, state_nxt;
  logic signed [ROOT_W-1:0] root_r, root_nxt;
  logic [DEG_W-1:0]         degree_r, degree_nxt;
  logic [DEG_W-1:0]         idx_r, idx_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [COEF_W-1:0]        root_ext;

  logic                     mem_we, mem_re;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [COEF_W-1:0]        mem_wdata, mem_rdata;

  logic                     mul_issue, emit_issue;

  logic                     s1_vld_r, s1_first_r;
  logic [DEG_W-1:0]         s1_widx_r;
  logic [COEF_W-1:0]        hold_r;
  logic signed [2*ROOT_W+1:0] plo_full;
  logic [ROOT_W-1:0]        phi_low;

  logic                     s2_vld_r;
  logic [DEG_W-1:0]         s2_widx_r;
  logic [COEF_W-1:0]        s2_plo_r, s2_prev_r;
  logic [ROOT_W-1:0]        s2_phi_r;

  logic                     s3_vld_r;
  logic [DEG_W-1:0]         s3_widx_r;
  logic [COEF_W-1:0]        s3_prod_r, s3_prev_r;

  logic                     em_pend_r;
  emit_tag_t                em_tag_r;
  out_item_t                rd_item;
  out_item_t                head_r, head_nxt, skid_r, skid_nxt;
  logic                     head_vld_r, head_vld_nxt, skid_vld_r, skid_vld_nxt;
  logic                     pop;
  logic [1:0]               used;
  logic                     can_issue;

  assign root_ext = {{(COEF_W-ROOT_W){root_r[ROOT_W-1]}}, root_r};

  pfr_ram #(
    .WIDTH(COEF_W),
    .DEPTH(MAX_DEGREE + 1)
  ) u_coef_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // Output side: head register plus one skid entry; reads are only issued with room to land.
  assign pop       = head_vld_r & out_ready;
  assign used      = {1'b0, head_vld_r} + {1'b0, skid_vld_r} + {1'b0, em_pend_r};
  assign can_issue = pop ? (used <= 2'd2) : (used <= 2'd1);
  assign out_valid = head_vld_r;
  assign out_data  = head_r;

  always_comb begin
    rd_item = '{coefficient: mem_rdata, power: em_tag_r.power,
                last: em_tag_r.last, overflow: em_tag_r.overflow};
  end

  always_comb begin
    state_nxt  = state_r;
    root_nxt   = root_r;
    degree_nxt = degree_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    cmd_ready  = 1'b0;
    mul_issue  = 1'b0;
    emit_issue = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    unique case (state_r)
      BK_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          root_nxt   = cmd.root;
          degree_nxt = cmd.degree;
          ovf_nxt    = cmd.overflow;
          unique case (cmd.kind)
            CMD_START: begin
              mem_we = 1'b1;
            end
            CMD_FIRST: begin
              mem_we    = 1'b1;
              mem_wdata = COEF_W'(1);
              state_nxt = BK_FIRST;
            end
            CMD_MUL: begin
              idx_nxt   = cmd.degree;
              state_nxt = BK_MUL;
            end
            CMD_EMIT: begin
              idx_nxt   = '0;
              state_nxt = BK_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      BK_FIRST: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(1);
        mem_wdata = '0 - root_ext;
        state_nxt = BK_IDLE;
      end
      BK_MUL: begin
        // Walk from the constant term up to the leading one; each read feeds the next term too.
        mul_issue = 1'b1;
        if (idx_r == '0) begin
          state_nxt = BK_DRAIN;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      BK_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_EMIT: begin
        if (can_issue) begin
          emit_issue = 1'b1;
          if (idx_r == degree_r) begin
            state_nxt = BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    if (s3_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = s3_widx_r[AW-1:0];
      mem_wdata = s3_prev_r - s3_prod_r;
    end
  end

  assign mem_re    = mul_issue | emit_issue;
  assign mem_raddr = idx_r[AW-1:0];

  // The 32 x 64 product is split into a low partial product and the low half of a high one.
  assign plo_full = root_r * $signed({1'b0, mem_rdata[ROOT_W-1:0]});
  assign phi_low  = $unsigned(root_r) * mem_rdata[COEF_W-1:ROOT_W];

  always_comb begin
    head_vld_nxt = head_vld_r;
    skid_vld_nxt = skid_vld_r;
    head_nxt     = head_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        head_nxt     = skid_r;
        skid_vld_nxt = em_pend_r;
        skid_nxt     = rd_item;
      end else begin
        head_vld_nxt = em_pend_r;
        head_nxt     = rd_item;
      end
    end else if (!head_vld_r) begin
      head_vld_nxt = em_pend_r;
      head_nxt     = rd_item;
    end else if (em_pend_r) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = rd_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      em_pend_r  <= 1'b0;
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      s1_vld_r   <= mul_issue;
      s2_vld_r   <= s1_vld_r;
      s3_vld_r   <= s2_vld_r;
      em_pend_r  <= emit_issue;
      head_vld_r <= head_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    root_r     <= root_nxt;
    degree_r   <= degree_nxt;
    idx_r      <= idx_nxt;
    ovf_r      <= ovf_nxt;
    head_r     <= head_nxt;
    skid_r     <= skid_nxt;
    s1_first_r <= (idx_r == degree_r);
    s1_widx_r  <= idx_r + 1'b1;
    if (s1_vld_r) begin
      hold_r <= mem_rdata;
    end
    s2_widx_r  <= s1_widx_r;
    s2_plo_r   <= plo_full[COEF_W-1:0];
    s2_phi_r   <= phi_low;
    s2_prev_r  <= s1_first_r ? '0 : hold_r;
    s3_widx_r  <= s2_widx_r;
    s3_prod_r  <= s2_plo_r + {s2_phi_r, {ROOT_W{1'b0}}};
    s3_prev_r  <= s2_prev_r;
    if (emit_issue) begin
      em_tag_r <= '{power: degree_r - idx_r, last: (idx_r == degree_r), overflow: ovf_r};
    end
  end

`ifndef NO_ASSERTIONS
  a_write_back_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (state_r == BK_MUL || state_r == BK_DRAIN))
    else $error("coefficient write-back outside a root walk");

  a_pipe_empty_on_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready) |-> !(s1_vld_r || s2_vld_r || s3_vld_r))
    else $error("new command taken while the multiply pipeline is busy");

  a_read_single_user: assert property (@(posedge clk) disable iff (!rst_n)
    em_pend_r |-> !s1_vld_r)
    else $error("read data claimed by both emit and multiply");

  a_skid_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> !em_pend_r)
    else $error("emit read arriving with the skid entry occupied");

  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid entry valid without a head beat");
`endif

endmodule

`default_nettype wire

@@ rtl/polynomial_from_roots.sv @@
`default_nettype none
// Items are accepted one per cycle while the four-entry command queue has room.
// Start is handled in the idle state; the first root writes two coefficients; a later root walks
// every coefficient with one read per cycle through a three-stage multiply-subtract.
// Emit: coefficient beats follow at one per cycle while out_ready stays high.
// Reset (rst_n low, synchronous) clears degree, overflow, queue and handshakes; the
// coefficient memory is not cleared; the user must write it before it is read (not enforced).

module polynomial_from_roots #(
  parameter int unsigned MAX_DEGREE = pfr_pkg::MAX_DEGREE_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfr_pkg::out_item_t out_data
);
  import pfr_pkg::*;

  logic push_valid, push_ready;
  cmd_t push_cmd;
  logic pop_valid, pop_ready;
  cmd_t pop_cmd;

  pfr_front #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd)
  );

  pfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_cmd  (push_cmd),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  pfr_back #(
    .MAX_DEGREE(MAX_DEGREE)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(pop_valid),
    .cmd_ready(pop_ready),
    .cmd      (pop_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ dv/tb_polynomial_from_roots.sv @@
`timescale 1ns / 1ps

module tb_polynomial_from_roots;
  import pfr_pkg::*;

  localparam int unsigned DEGREE_LIMIT = MAX_DEGREE_DEF;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;
  localparam int          RANDOM_ITEMS = 345;
  localparam int          TAIL_ITEMS   = 40;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  polynomial_from_roots uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expectations.
  in_item_t    pending_items[$];
  out_item_t   expected_coefs[$];
  logic [63:0] poly_coef[DEGREE_LIMIT+1];
  int          poly_degree = 0;
  bit          poly_started = 1'b0;
  bit          poly_overflow = 1'b0;

  int          items_accepted = 0;
  int          error_count = 0;
  bit          tail_phase = 1'b0;
  bit          rx_hold_active = 1'b0;
  bit          hold_done = 1'b0;
  int          hold_left = 0;
  int          send_gap = 0;
  int          rx_gap = 0;
  out_item_t   oldest;

  // Generator-side knowledge: an emit is only legal once a coefficient was written.
  bit          gen_written = 1'b0;
  int          gen_count = 0;

  task automatic predict_coefficients(input in_item_t item);
    logic [63:0] r64;
    out_item_t   beat;
    int          i;
    r64 = {{32{item.root[31]}}, item.root};
    case (item.operation)
      OP_START: begin
        poly_coef[0]  = '0;
        poly_degree   = 0;
        poly_started  = 1'b0;
        poly_overflow = 1'b0;
      end
      OP_ROOT: begin
        if (!poly_started) begin
          poly_coef[0] = 64'd1;
          poly_coef[1] = -r64;
          poly_degree  = 1;
          poly_started = 1'b1;
        end else if (poly_degree >= DEGREE_LIMIT) begin
          poly_overflow = 1'b1;
        end else begin
          poly_coef[poly_degree+1] = -(r64 * poly_coef[poly_degree]);
          for (i = poly_degree; i >= 1; i--) begin
            poly_coef[i] = poly_coef[i] - r64 * poly_coef[i-1];
          end
          poly_degree++;
        end
      end
      OP_EMIT: begin
        for (i = 0; i <= poly_degree; i++) begin
          beat.coefficient = poly_coef[i];
          beat.power       = 6'(poly_degree - i);
          beat.last        = (i == poly_degree);
          beat.overflow    = poly_overflow;
          expected_coefs.push_back(beat);
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_root();
    case ($urandom_range(0, 5))
      0, 1: pick_root = 32'($signed($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: pick_root = 32'h8000_0000;
          1: pick_root = 32'h7fff_ffff;
          2: pick_root = 32'hffff_ffff;
          default: pick_root = 32'h0000_0000;
        endcase
      end
      default: pick_root = $urandom();
    endcase
  endfunction

  task automatic add_item(input logic [1:0] op, input logic [31:0] root);
    in_item_t item;
    if (op == OP_EMIT && !gen_written) op = OP_START;
    if (op == OP_START || op == OP_ROOT) gen_written = 1'b1;
    if (op != OP_UNUSED) gen_count++;
    item.operation = op;
    item.root      = root;
    pending_items.push_back(item);
  endtask

  // One well-formed polynomial: start, a run of roots with emits mixed in, a final emit.
  task automatic add_polynomial(input int n_roots);
    int k;
    add_item(OP_START, $urandom());
    for (k = 1; k <= n_roots; k++) begin
      add_item(OP_ROOT, pick_root());
      if (k == DEGREE_LIMIT || $urandom_range(0, 99) < 15) add_item(OP_EMIT, $urandom());
    end
    add_item(OP_EMIT, $urandom());
    if ($urandom_range(0, 9) == 0) add_item(OP_EMIT, $urandom());
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_coefficients(in_data);
        items_accepted <= items_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0 && !rx_hold_active) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
          send_gap = 0;
          if (!tail_phase && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 13);
        end else begin
          in_valid <= 1'b0;
        end
      end
      tail_phase <= (pending_items.size() < TAIL_ITEMS);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_coefs.size() == 0) begin
          $error("coefficient beat with nothing expected: coefficient %0d power %0d",
                 out_data.coefficient, out_data.power);
          error_count++;
        end else begin
          oldest = expected_coefs.pop_front();
          if (out_data.coefficient !== oldest.coefficient) begin
            $error("coefficient: expected %0d, actual %0d",
                   oldest.coefficient, out_data.coefficient);
            error_count++;
          end
          if (out_data.power !== oldest.power) begin
            $error("power: expected %0d, actual %0d", oldest.power, out_data.power);
            error_count++;
          end
          if (out_data.last !== oldest.last) begin
            $error("last: expected %0b, actual %0b", oldest.last, out_data.last);
            error_count++;
          end
          if (out_data.overflow !== oldest.overflow) begin
            $error("overflow: expected %0b, actual %0b", oldest.overflow, out_data.overflow);
            error_count++;
          end
        end
      end
      // A single long hold-off lets the command queue back up and stall the input.
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
        if (hold_left == 0) rx_hold_active <= 1'b0;
      end else if (!hold_done && items_accepted >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        rx_hold_active <= 1'b1;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 9) == 0) begin
        rx_gap = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int seq_idx;
    int n_roots;
    int pick;
    int start_count;

    // Directed part. The first root follows an unused code right after reset, without a start.
    add_item(OP_UNUSED, $urandom());
    add_item(OP_ROOT, 32'd5);
    add_item(OP_EMIT, '0);
    add_item(OP_START, '0);
    add_item(OP_EMIT, '0);
    add_item(OP_ROOT, 32'h8000_0000);
    add_item(OP_ROOT, 32'h7fff_ffff);
    add_item(OP_ROOT, 32'hffff_ffff);
    add_item(OP_EMIT, 32'hffff_ffff);
    add_item(OP_UNUSED, 32'h7fff_ffff);
    add_item(OP_EMIT, '0);
    add_item(OP_START, 32'h8000_0000);
    add_item(OP_ROOT, 32'd0);
    add_item(OP_ROOT, 32'd0);
    add_item(OP_EMIT, '0);
    add_item(OP_START, '0);
    add_item(OP_ROOT, 32'd3);
    add_item(OP_ROOT, -32'sd3);
    add_item(OP_ROOT, 32'd1);
    add_item(OP_EMIT, '0);
    add_item(OP_EMIT, '0);

    // Random part: mostly whole polynomials, a few running past the degree limit.
    start_count = gen_count;
    seq_idx = 0;
    while (gen_count - start_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (seq_idx == 2 || seq_idx == 9) begin
        add_polynomial(DEGREE_LIMIT + 3);
      end else if (pick < 85) begin
        n_roots = $urandom_range(0, 6);
        if ($urandom_range(0, 99) < 10) n_roots = $urandom_range(7, 20);
        else if ($urandom_range(0, 99) < 6) n_roots = $urandom_range(60, 70);
        add_polynomial(n_roots);
      end else begin
        add_item(2'($urandom_range(0, 3)), pick_root());
      end
      seq_idx++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_coefs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_coefs.size() != 0) begin
      $error("%0d expected coefficient beats never arrived", expected_coefs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
